/* hdl/ufpc_pkg.sv */
// shared types and constants for the union-find engine
// no dependencies; used by every module of the block
package ufpc_pkg;

  // table geometry
  localparam int NODES  = 1024;
  localparam int IDX_W  = 10;
  localparam int ADDR_W = $clog2(NODES);

  // request codes on func
  localparam logic OP_FIND = 1'b0;
  localparam logic OP_JOIN = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // one access to the parent table in a cycle: a read and a write
  typedef struct packed {
    logic  re;
    addr_t raddr;
    logic  we;
    addr_t waddr;
    idx_t  wdata;
  } tbl_req_t;

  // a node index that has an entry in the table
  function automatic logic in_table(input idx_t idx);
    in_table = (32'(idx) < 32'(NODES));
  endfunction

endpackage

/* hdl/ufpc_table.sv */
// parent table: one write port and one registered read port
// depends on ufpc_pkg for the request struct and index types
module ufpc_table (
  input  logic               clk_i,
  input  ufpc_pkg::tbl_req_t req_i,
  output ufpc_pkg::idx_t     rdata_o
);

  ufpc_pkg::idx_t mem_q [ufpc_pkg::NODES];
  ufpc_pkg::idx_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      if (req_i.we && (req_i.waddr == req_i.raddr)) begin
        rdata_q <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/union_find_path_compression.sv */
// Disjoint-set engine with path compression over a 1024-entry parent table.
// Depends on ufpc_pkg and ufpc_table.
//
// Input channel (in_valid_i / in_stall_o) carries one request item:
// func_i = 0 finds the root of node_a_i, func_i = 1 joins the sets of
// node_a_i and node_b_i (root of node_a_i becomes the parent of the other
// root). Output channel (out_valid_o / out_stall_i) returns one item per
// request: root_o is the root of node_a_i after the operation, same_set_o
// is 1 for a join whose two roots were already equal.
//
// Walk: a walk over a path starts, reads its links going up to the root,
// rewrites each link to point at the root in read-and-rewrite steps coming
// down, then finishes. A find is one walk and a join two, and the result is
// registered when the last walk finishes; the engine returns to idle before the next
// item is taken, even while the previous result still waits at the output.
//
// Reset: the table is swept to identity, one entry per cycle, with in_stall_o
// high. A stalled result holds in the output register and
// the engine waits with the next result until the register is free.
module union_find_path_compression (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  ufpc_pkg::idx_t       node_a_i,
  input  ufpc_pkg::idx_t       node_b_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ufpc_pkg::idx_t       root_o,
  output logic                 same_set_o
);

  // state codes
  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_UP    = 3'd3;
  localparam logic [2:0] S_DOWN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam ufpc_pkg::addr_t CLR_LAST = ufpc_pkg::ADDR_W'(ufpc_pkg::NODES - 1);

  logic [2:0]         state_q, state_d;
  ufpc_pkg::addr_t    clr_q, clr_d;
  logic               func_q, func_d;
  logic               sel_b_q, sel_b_d;
  ufpc_pkg::idx_t     node_q, node_d;
  ufpc_pkg::idx_t     node_b_q, node_b_d;
  ufpc_pkg::idx_t     top_q, top_d;
  ufpc_pkg::idx_t     cur_q, cur_d;
  ufpc_pkg::idx_t     ra_q, ra_d;
  logic               out_valid_q, out_valid_d;
  ufpc_pkg::idx_t     root_q, root_d;
  logic               same_q, same_d;

  ufpc_pkg::tbl_req_t req;
  ufpc_pkg::idx_t     rdata;
  logic               out_free;
  logic               in_acc;

  ufpc_table u_table (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // sequencer: walk up to the root, walk down rewriting links, then for a join link roots
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    sel_b_d     = sel_b_q;
    node_d      = node_q;
    node_b_d    = node_b_q;
    top_d       = top_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    root_d      = root_q;
    same_d      = same_q;
    out_valid_d = out_valid_q && out_stall_i;
    req         = '0;

    unique case (state_q)
      S_CLR: begin
        req.we    = 1'b1;
        req.waddr = clr_q;
        req.wdata = ufpc_pkg::idx_t'(clr_q);
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          func_d   = func_i;
          node_d   = node_a_i;
          node_b_d = node_b_i;
          sel_b_d  = 1'b0;
          state_d  = S_START;
        end
      end
      S_START: begin
        top_d = node_q;
        if (ufpc_pkg::in_table(node_q)) begin
          req.re    = 1'b1;
          req.raddr = node_q[ufpc_pkg::ADDR_W-1:0];
          state_d   = S_UP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UP: begin
        if (rdata == top_q) begin
          if (node_q == top_q) begin
            state_d = S_FIN;
          end else begin
            cur_d     = node_q;
            req.re    = 1'b1;
            req.raddr = node_q[ufpc_pkg::ADDR_W-1:0];
            state_d   = S_DOWN;
          end
        end else begin
          top_d     = rdata;
          req.re    = 1'b1;
          req.raddr = rdata[ufpc_pkg::ADDR_W-1:0];
        end
      end
      S_DOWN: begin
        req.we    = 1'b1;
        req.waddr = cur_q[ufpc_pkg::ADDR_W-1:0];
        req.wdata = top_q;
        if (rdata == top_q) begin
          state_d = S_FIN;
        end else begin
          cur_d     = rdata;
          req.re    = 1'b1;
          req.raddr = rdata[ufpc_pkg::ADDR_W-1:0];
        end
      end
      S_FIN: begin
        if (!sel_b_q) begin
          ra_d = top_q;
          if (func_q == ufpc_pkg::OP_JOIN) begin
            node_d  = node_b_q;
            sel_b_d = 1'b1;
            state_d = S_START;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            root_d      = top_q;
            same_d      = 1'b0;
            state_d     = S_IDLE;
          end
        end else if (out_free) begin
          // link second root under the first
          req.we      = ufpc_pkg::in_table(top_q) && ufpc_pkg::in_table(ra_q);
          req.waddr   = top_q[ufpc_pkg::ADDR_W-1:0];
          req.wdata   = ra_q;
          out_valid_d = 1'b1;
          root_d      = ra_q;
          same_d      = (ra_q == top_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    sel_b_q  <= sel_b_d;
    node_q   <= node_d;
    node_b_q <= node_b_d;
    top_q    <= top_d;
    cur_q    <= cur_d;
    ra_q     <= ra_d;
    root_q   <= root_d;
    same_q   <= same_d;
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;
  assign same_set_o  = same_q;

endmodule

/* hdl/ufpc_checker.sv */
// port-level checks for the union-find engine, bound to the top level
// depends on ufpc_pkg and union_find_path_compression
module ufpc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ufpc_pkg::idx_t root_o,
  input logic           same_set_o
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // table sweep holds off requests right after reset
  a_stall_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken during table sweep");

  // a result only ever follows an accepted item
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 2'd0))
    else $error("result without a request");

  // at most one item in work and one waiting in the output register
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(root_o) && $stable(same_set_o))
    else $error("stalled result changed");

endmodule

bind union_find_path_compression ufpc_checker u_ufpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .root_o      (root_o),
  .same_set_o  (same_set_o)
);
